// ----- hw/rtl/csab_pkg.sv -----
// Package for the cell-average shunt balancer: field widths, codes,
// reset values, state and ALU types. No dependencies.
package csab_pkg;

   localparam int WINDOW     = 8;
   localparam int SLOT_W     = 3;
   localparam int KIND_W     = 2;
   localparam int CELL_IDX_W = 5;
   localparam int CODE_W     = 12;
   localparam int MV_W       = 13;
   localparam int THR_W      = 16;
   localparam int CORR_W     = 4;
   localparam int TIMER_W    = 8;
   localparam int MASK_W     = 24;
   localparam int ACC_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_CORR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_CORR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd3;

   localparam logic [CORR_W-1:0]  RST_LOW_CORR  = 4'd6;
   localparam logic [CORR_W-1:0]  RST_HIGH_CORR = 4'd6;
   localparam logic [MV_W-1:0]    RST_LIMIT     = 13'd5000;
   localparam logic [TIMER_W-1:0] RST_TIMEOUT   = 8'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_CORR,
      ST_HALF,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
   } alu_ctl_type;

endpackage

// ----- hw/rtl/csab_if.sv -----
// Handshake interfaces for the request and response channels.
// Depends on csab_pkg for the field widths.
interface csab_req_if;
   import csab_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [CELL_IDX_W-1:0] cell_req;
   logic [CODE_W-1:0]     raw_code;
   logic [THR_W-1:0]      threshold_mv;

   modport source (output valid, kind, cell_req, raw_code, threshold_mv, input ready);
   modport sink   (input valid, kind, cell_req, raw_code, threshold_mv, output ready);
endinterface

interface csab_rsp_if;
   import csab_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CELL_IDX_W-1:0] cell_index;
   logic [MV_W-1:0]       voltage_mv;
   logic                  shunt_on;
   logic [MASK_W-1:0]     shunt_mask;
   logic                  cells_present;
   logic                  last;

   modport source (output valid, cell_index, voltage_mv, shunt_on, shunt_mask,
                   cells_present, last, input ready);
   modport sink   (input valid, cell_index, voltage_mv, shunt_on, shunt_mask,
                   cells_present, last, output ready);
endinterface

// ----- hw/rtl/cell_average_shunt_balancer.sv -----
// Top level of the cell-average shunt balancer.
// Depends on csab_pkg, csab_if, csab_ram and csab_alu.

// The balancer keeps a window of eight millivolt samples for each cell in a
// RAM and, on the round tick that wraps the slot counter, emits one response
// transaction per cell in ascending order with the corrected average, the
// shunt decision and the running shunt mask. A cell sample, a balance request
// or a round tick that does not wrap is taken without leaving the idle state,
// so the block stays ready. A wrapping tick starts a round that walks the cells
// one at a time through the single RAM read port and the shared adder: the
// reads of the window, a drain of the read pipeline, the correction, the
// half-correction, the decision, and the hand-over of the response, which
// is held while the response side stalls. The request channel is not ready
// during a round. The sample store needs no clearing pass: one valid bit
// per entry, cleared by reset, makes a never-written entry read as zero. The
// comms timer is advanced once the round has finished, so the round sees the
// threshold that was in force when the tick arrived.
module cell_average_shunt_balancer #(
   parameter int NUM_CELLS  = 24,
   parameter int GROUP_SIZE = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [csab_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [csab_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   csab_req_if.sink                           req_bus,
   csab_rsp_if.source                         rsp_bus
);
   import csab_pkg::*;

   localparam int CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int ADDR_W = CELL_W + SLOT_W;
   localparam int DEPTH  = NUM_CELLS * WINDOW;

   // Configuration registers.
   logic [CORR_W-1:0]  low_corr_ff, low_corr_in;
   logic [CORR_W-1:0]  high_corr_ff, high_corr_in;
   logic [MV_W-1:0]    limit_ff, limit_in;
   logic [TIMER_W-1:0] timeout_ff, timeout_in;

   // Control state.
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [NUM_CELLS-1:0] shunt_ff, shunt_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               acc_en_ff, acc_en_in;
   logic               nz_ff, nz_in;
   logic               present_ff, present_in;
   logic               rd_valid_ff, rd_valid_in;

   // Response payload registers.
   logic [MV_W-1:0]    out_volt_ff, out_volt_in;
   logic               out_on_ff, out_on_in;
   logic [MASK_W-1:0]  out_mask_ff, out_mask_in;
   logic               out_present_ff, out_present_in;
   logic               out_last_ff, out_last_in;

   // Datapath signals.
   alu_ctl_type        alu_ctl;
   logic [ACC_W-1:0]   alu_res;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [MV_W-1:0]    wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [MV_W-1:0]    rd_data;
   logic [MV_W-2:0]    rd_half;
   logic [CORR_W-1:0]  corr;
   logic               is_last;
   logic               edge_cell;
   logic               cell_in_range;
   logic               do_timer;
   logic [ACC_W-1:0]   final_mv;
   logic               shunt_dec;
   logic [31:0]        mask_wide;

   csab_ram #(
      .WIDTH(MV_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   csab_alu u_alu (
      .ctl(alu_ctl),
      .res(alu_res)
   );

   // A sample is stored at {cell, slot}; a round reads {cell, window position}.
   assign wr_addr = {req_bus.cell_req[CELL_W-1:0], slot_ff};
   assign rd_addr = {cell_ff, cnt_ff};
   assign rd_half = rd_valid_ff ? rd_data[MV_W-1:1] : '0;

   assign cell_in_range = ({1'b0, req_bus.cell_req} < (CELL_IDX_W + 1)'(NUM_CELLS));
   assign is_last   = (cell_ff == CELL_W'(NUM_CELLS - 1));
   assign edge_cell = (cell_ff == '0) || (6'(cell_ff) == 6'(GROUP_SIZE));
   assign corr      = (6'(cell_ff) < 6'(GROUP_SIZE)) ? low_corr_ff : high_corr_ff;

   // The decision works on the corrected value held in the accumulator.
   assign final_mv  = (acc_ff > ACC_W'(limit_ff)) ? '0 : acc_ff;
   assign shunt_dec = (final_mv > thr_ff) && (thr_ff != '0);

   // Configuration writes.
   always_comb begin
      low_corr_in  = low_corr_ff;
      high_corr_in = high_corr_ff;
      limit_in     = limit_ff;
      timeout_in   = timeout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_CORR:  low_corr_in  = csr_wr_data[CORR_W-1:0];
            CSR_HIGH_CORR: high_corr_in = csr_wr_data[CORR_W-1:0];
            CSR_LIMIT:     limit_in     = csr_wr_data[MV_W-1:0];
            CSR_TIMEOUT:   timeout_in   = csr_wr_data[TIMER_W-1:0];
            default:       ;
         endcase
      end
   end

   // Sequencer: next state, datapath control and next values.
   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      timer_in       = timer_ff;
      thr_in         = thr_ff;
      shunt_in       = shunt_ff;
      valid_in       = valid_ff;
      cell_in        = cell_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      acc_en_in      = 1'b0;
      nz_in          = nz_ff;
      present_in     = present_ff;
      out_volt_in    = out_volt_ff;
      out_on_in      = out_on_ff;
      out_mask_in    = out_mask_ff;
      out_present_in = out_present_ff;
      out_last_in    = out_last_ff;
      mask_wide      = 32'(shunt_ff);
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      do_timer       = 1'b0;

      // While idle the adder forms code*3 for an incoming sample.
      alu_ctl.op = ALU_ADD;
      alu_ctl.a  = ACC_W'(req_bus.raw_code);
      alu_ctl.b  = ACC_W'({req_bus.raw_code, 1'b0});
      wr_data    = alu_res[MV_W:1];

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (req_bus.kind)
                  KIND_SAMPLE: begin
                     if (cell_in_range) begin
                        wr_en             = 1'b1;
                        valid_in[wr_addr] = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     slot_in = slot_ff + 1'b1;
                     if (slot_in == '0) begin
                        state_in   = ST_SUM;
                        cell_in    = '0;
                        cnt_in     = '0;
                        acc_in     = '0;
                        present_in = 1'b0;
                     end else begin
                        do_timer = 1'b1;
                     end
                  end
                  KIND_REQUEST: begin
                     thr_in   = req_bus.threshold_mv;
                     timer_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SUM: begin
            // One read a cycle; its data is added in the following cycle.
            rd_en     = 1'b1;
            acc_en_in = 1'b1;
            alu_ctl.a = acc_ff;
            alu_ctl.b = ACC_W'(rd_half);
            if (acc_en_ff) begin
               acc_in = alu_res;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SLOT_W'(WINDOW - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            alu_ctl.a = acc_ff;
            alu_ctl.b = ACC_W'(rd_half);
            acc_in    = alu_res;
            state_in  = ST_CORR;
         end
         ST_CORR: begin
            alu_ctl.a = acc_ff >> 2;
            alu_ctl.b = ACC_W'(corr);
            nz_in     = ((acc_ff >> 2) != '0);
            acc_in    = nz_in ? alu_res : '0;
            state_in  = ST_HALF;
         end
         ST_HALF: begin
            alu_ctl.op = ALU_SUB;
            alu_ctl.a  = acc_ff;
            alu_ctl.b  = ACC_W'(corr >> 1);
            if (nz_ff && edge_cell) begin
               acc_in = alu_res;
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            shunt_in[cell_ff] = shunt_dec;
            mask_wide         = 32'(shunt_in);
            present_in        = present_ff || (final_mv != '0);
            out_volt_in       = final_mv[MV_W-1:0];
            out_on_in         = shunt_dec;
            out_mask_in       = mask_wide[MASK_W-1:0];
            out_present_in    = present_in;
            out_last_in       = is_last;
            state_in          = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_bus.ready) begin
               if (is_last) begin
                  state_in = ST_IDLE;
                  do_timer = 1'b1;
               end else begin
                  cell_in  = cell_ff + 1'b1;
                  cnt_in   = '0;
                  acc_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Comms timer: count up to the timeout, then keep clearing the threshold.
      if (do_timer) begin
         if (timer_ff < timeout_ff) begin
            timer_in = timer_ff + 1'b1;
         end else begin
            thr_in = '0;
         end
      end

      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_corr_ff  <= RST_LOW_CORR;
         high_corr_ff <= RST_HIGH_CORR;
         limit_ff     <= RST_LIMIT;
         timeout_ff   <= RST_TIMEOUT;
         slot_ff      <= '0;
         timer_ff     <= '0;
         thr_ff       <= '0;
         shunt_ff     <= '0;
         valid_ff     <= '0;
         cell_ff      <= '0;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         acc_en_ff    <= 1'b0;
         nz_ff        <= 1'b0;
         present_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         low_corr_ff  <= low_corr_in;
         high_corr_ff <= high_corr_in;
         limit_ff     <= limit_in;
         timeout_ff   <= timeout_in;
         slot_ff      <= slot_in;
         timer_ff     <= timer_in;
         thr_ff       <= thr_in;
         shunt_ff     <= shunt_in;
         valid_ff     <= valid_in;
         cell_ff      <= cell_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         acc_en_ff    <= acc_en_in;
         nz_ff        <= nz_in;
         present_ff   <= present_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_volt_ff    <= out_volt_in;
      out_on_ff      <= out_on_in;
      out_mask_ff    <= out_mask_in;
      out_present_ff <= out_present_in;
      out_last_ff    <= out_last_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = (state_ff == ST_EMIT);
   assign rsp_bus.cell_index    = CELL_IDX_W'(cell_ff);
   assign rsp_bus.voltage_mv    = out_volt_ff;
   assign rsp_bus.shunt_on      = out_on_ff;
   assign rsp_bus.shunt_mask    = out_mask_ff;
   assign rsp_bus.cells_present = out_present_ff;
   assign rsp_bus.last          = out_last_ff;

endmodule

// ----- hw/rtl/csab_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csab_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ----- hw/rtl/csab_alu.sv -----
// Shared adder/subtractor used for the sample scaling, window sum and corrections of the balancer.
// Depends on csab_pkg for the control struct.
module csab_alu (
   input  csab_pkg::alu_ctl_type      ctl,
   output logic [csab_pkg::ACC_W-1:0] res
);
   import csab_pkg::*;

   always_comb begin
      case (ctl.op)
         ALU_ADD: res = ctl.a + ctl.b;
         ALU_SUB: res = ctl.a - ctl.b;
         default: res = ctl.a;
      endcase
   end
endmodule
